// ===== src/bgmr_pkg.sv =====
package bgmr_pkg;

	// Matrix geometry
	localparam int COLUMNS = 7;
	localparam int ROWS = 7;
	localparam int PIXELS = COLUMNS * ROWS;
	localparam int PIX_W = 24;
	localparam int IDX_W = 6;
	localparam logic [IDX_W-1:0] LAST_PIX = IDX_W'(PIXELS - 1);

	// Configuration register indexes
	localparam logic [1:0] CFG_FALL_DELAY = 2'd0;
	localparam logic [1:0] CFG_COLOR_ONE = 2'd1;
	localparam logic [1:0] CFG_COLOR_TWO = 2'd2;
	localparam logic [1:0] CFG_COLOR_THREE = 2'd3;

	// Fade phases
	localparam logic [1:0] FADE_RED_GREEN = 2'd0;
	localparam logic [1:0] FADE_GREEN_BLUE = 2'd1;
	localparam logic [1:0] FADE_BLUE_RED = 2'd2;

	// Fade step and channel limit
	localparam logic [7:0] FADE_STEP = 8'd5;
	localparam logic [7:0] CHAN_MAX = 8'd255;

	typedef logic [PIX_W-1:0] pixel_t;

	typedef struct packed {
		logic signed [3:0] level_col0;
		logic signed [3:0] level_col1;
		logic signed [3:0] level_col2;
		logic signed [3:0] level_col3;
		logic signed [3:0] level_col4;
		logic signed [3:0] level_col5;
		logic signed [3:0] level_col6;
		logic [1:0] shape_mode;
		logic [4:0] color_mode;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] pixel_index;
		logic [PIX_W-1:0] pixel_color;
		logic last_pixel;
	} out_item_t;

	// Per-frame paint decision from the prep unit
	typedef struct packed {
		logic drop;
		pixel_t pal0;
		pixel_t pal1;
		pixel_t pal2;
		logic pal_eq;
	} paint_t;

	// Control shared by all column cells
	typedef struct packed {
		logic update;
		logic shift;
		logic keep;
		logic line;
		logic band;
		paint_t paint;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	// Keep only the highest set bit of a column mask
	function automatic logic [ROWS-1:0] top_only(input logic [ROWS-1:0] m);
		logic [ROWS-1:0] r;
		logic seen;
		r = '0;
		seen = 1'b0;
		for (int y = ROWS - 1; y >= 0; y--) begin
			if (m[y] && !seen) begin
				r[y] = 1'b1;
			end
			seen = seen | m[y];
		end
		return r;
	endfunction

endpackage

// ===== src/bgmr_cell.sv =====
module bgmr_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bgmr_pkg::cell_ctl_t   ctl,
	input  logic signed [3:0]     level,
	input  bgmr_pkg::pixel_t      shift_in,
	output bgmr_pkg::pixel_t      head
);

	bgmr_pkg::pixel_t pix_q [bgmr_pkg::ROWS];
	bgmr_pkg::pixel_t new_pix [bgmr_pkg::ROWS];
	logic [bgmr_pkg::ROWS-1:0] m0, m1, m2, tm;
	logic [1:0] cnt;

	assign head = pix_q[0];

	// Build the lit mask: old cells in delay mode plus the new bar
	always_comb begin
		for (int y = 0; y < bgmr_pkg::ROWS; y++) begin
			m0[y] = (ctl.keep && (pix_q[y] != '0)) ||
				(!level[3] && (3'(y) <= level[2:0]));
		end
	end

	// Drop the top cell one row when a fall is due, then keep only the top in line mode
	always_comb begin
		tm = bgmr_pkg::top_only(m0);
		if (ctl.paint.drop && !tm[0]) begin
			m1 = (m0 & ~tm) | (tm >> 1);
		end else begin
			m1 = m0;
		end
		m2 = ctl.line ? bgmr_pkg::top_only(m1) : m1;
	end

	// Paint lit cells by row band or by rank from the top
	always_comb begin
		cnt = 2'd0;
		for (int y = bgmr_pkg::ROWS - 1; y >= 0; y--) begin
			new_pix[y] = '0;
			if (m2[y]) begin
				if (ctl.band) begin
					if (y > 5) begin
						new_pix[y] = ctl.paint.pal2;
					end else if (y > 3) begin
						new_pix[y] = ctl.paint.pal1;
					end else begin
						new_pix[y] = ctl.paint.pal0;
					end
				end else begin
					if (cnt == 2'd0) begin
						new_pix[y] = ctl.paint.pal2;
					end else if (cnt == 2'd1) begin
						new_pix[y] = ctl.paint.pal1;
					end else begin
						new_pix[y] = ctl.paint.pal0;
					end
					if (ctl.paint.pal_eq || cnt != 2'd0) begin
						cnt = 2'd2;
					end else begin
						cnt = 2'd1;
					end
				end
			end
		end
	end

	// Load the repainted column, or advance the ring by one pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int y = 0; y < bgmr_pkg::ROWS; y++) begin
				pix_q[y] <= '0;
			end
		end else if (ctl.update) begin
			for (int y = 0; y < bgmr_pkg::ROWS; y++) begin
				pix_q[y] <= new_pix[y];
			end
		end else if (ctl.shift) begin
			for (int y = 0; y < bgmr_pkg::ROWS - 1; y++) begin
				pix_q[y] <= pix_q[y + 1];
			end
			pix_q[bgmr_pkg::ROWS - 1] <= shift_in;
		end
	end

endmodule

// ===== src/bgmr_prep.sv =====
module bgmr_prep (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              keep,
	input  logic [4:0]        color_mode,
	input  logic [31:0]       now_ms,
	input  logic [31:0]       fall_delay,
	input  bgmr_pkg::pixel_t  color_one,
	input  bgmr_pkg::pixel_t  color_two,
	input  bgmr_pkg::pixel_t  color_three,
	output bgmr_pkg::paint_t  paint_s2
);

	logic [31:0] last_fall_q;
	logic [31:0] fall_due;
	logic do_drop;
	logic [7:0] red_q, green_q, blue_q;
	logic [1:0] phase_q;
	logic [7:0] red_n, green_n, blue_n;
	logic [1:0] phase_n;
	logic b1, b2, b3;
	bgmr_pkg::pixel_t fade_col, p0, p1, p2;

	// Decide whether the peaks fall this frame
	assign fall_due = last_fall_q + fall_delay;
	assign do_drop = keep && (fall_due < now_ms);

	// Step the fade one notch
	always_comb begin
		red_n = red_q;
		green_n = green_q;
		blue_n = blue_q;
		phase_n = phase_q;
		case (phase_q)
			bgmr_pkg::FADE_RED_GREEN: begin
				red_n = red_q - bgmr_pkg::FADE_STEP;
				green_n = green_q + bgmr_pkg::FADE_STEP;
				blue_n = '0;
				if (green_n == bgmr_pkg::CHAN_MAX) begin
					red_n = '0;
					phase_n = bgmr_pkg::FADE_GREEN_BLUE;
				end
			end
			bgmr_pkg::FADE_GREEN_BLUE: begin
				red_n = '0;
				green_n = green_q - bgmr_pkg::FADE_STEP;
				blue_n = blue_q + bgmr_pkg::FADE_STEP;
				if (blue_n == bgmr_pkg::CHAN_MAX) begin
					green_n = '0;
					phase_n = bgmr_pkg::FADE_BLUE_RED;
				end
			end
			bgmr_pkg::FADE_BLUE_RED: begin
				red_n = red_q + bgmr_pkg::FADE_STEP;
				green_n = '0;
				blue_n = blue_q - bgmr_pkg::FADE_STEP;
				if (red_n == bgmr_pkg::CHAN_MAX) begin
					blue_n = '0;
					phase_n = bgmr_pkg::FADE_RED_GREEN;
				end
			end
			default: begin
				phase_n = bgmr_pkg::FADE_RED_GREEN;
			end
		endcase
	end

	// Pick the three palette slots
	assign fade_col = {red_n, green_n, blue_n};
	assign b1 = color_mode[0];
	assign b2 = color_mode[1];
	assign b3 = color_mode[2];

	always_comb begin
		if (color_mode[4]) begin
			p0 = fade_col;
			p1 = fade_col;
			p2 = fade_col;
		end else begin
			p0 = b1 ? color_one : b2 ? color_two : b3 ? color_three : '0;
			p1 = b2 ? color_two : b3 ? color_three : b1 ? color_one : '0;
			p2 = b3 ? color_three : b2 ? color_two : b1 ? color_one : '0;
		end
	end

	// Hold fall time and fade state across frames
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_fall_q <= '0;
			red_q <= bgmr_pkg::CHAN_MAX;
			green_q <= '0;
			blue_q <= '0;
			phase_q <= bgmr_pkg::FADE_RED_GREEN;
		end else if (en) begin
			if (do_drop) begin
				last_fall_q <= now_ms;
			end
			if (color_mode[4]) begin
				red_q <= red_n;
				green_q <= green_n;
				blue_q <= blue_n;
				phase_q <= phase_n;
			end
		end
	end

	// Register the paint decision for the cells
	always_ff @(posedge clk) begin
		if (en) begin
			paint_s2.drop <= do_drop;
			paint_s2.pal0 <= p0;
			paint_s2.pal1 <= p1;
			paint_s2.pal2 <= p2;
			paint_s2.pal_eq <= (p1 == p2);
		end
	end

endmodule

// ===== src/bar_graph_matrix_renderer.sv =====
// Renders one 7x7 bar-graph frame per input item and returns 49 pixel items in
// column-major order, the last one flagged. An item goes through these steps in
// order: the frame is registered; the fall timer, fade step and palette are
// registered; the seven column cells repaint their columns together; and the
// cells shift the stored pixels one place along their ring into the output
// register. That ring shift, one pixel per cycle while the output is not
// stalled, sets the rate. The next item is taken as soon as the last pixel
// sits in the output register. The pixel store clears at reset; configuration
// writes are taken at any time and should land while the block is idle.
module bar_graph_matrix_renderer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  bgmr_pkg::in_item_t    in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output bgmr_pkg::out_item_t   out_item,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data
);

	bgmr_pkg::state_t state_q, state_n;
	bgmr_pkg::in_item_t in_s1;
	bgmr_pkg::paint_t paint_s2;
	bgmr_pkg::cell_ctl_t cell_ctl;
	bgmr_pkg::out_item_t out_item_q;
	logic out_valid_q;
	logic [bgmr_pkg::IDX_W-1:0] pix_cnt_q;
	logic [31:0] fall_delay_q;
	bgmr_pkg::pixel_t color_one_q, color_two_q, color_three_q;
	logic accept, prep_en, update, out_load;
	logic signed [3:0] level [bgmr_pkg::COLUMNS];
	bgmr_pkg::pixel_t col_head [bgmr_pkg::COLUMNS];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fall_delay_q <= 32'd100;
			color_one_q <= 24'hFF0000;
			color_two_q <= 24'h00FF00;
			color_three_q <= 24'h0000FF;
		end else if (cfg_we) begin
			case (cfg_index)
				bgmr_pkg::CFG_FALL_DELAY: fall_delay_q <= cfg_data;
				bgmr_pkg::CFG_COLOR_ONE: color_one_q <= cfg_data[23:0];
				bgmr_pkg::CFG_COLOR_TWO: color_two_q <= cfg_data[23:0];
				bgmr_pkg::CFG_COLOR_THREE: color_three_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			bgmr_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_n = bgmr_pkg::ST_PREP;
				end
			end
			bgmr_pkg::ST_PREP: state_n = bgmr_pkg::ST_UPDATE;
			bgmr_pkg::ST_UPDATE: state_n = bgmr_pkg::ST_EMIT;
			bgmr_pkg::ST_EMIT: begin
				if (out_load && pix_cnt_q == bgmr_pkg::LAST_PIX) begin
					state_n = bgmr_pkg::ST_IDLE;
				end
			end
			default: state_n = bgmr_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_stall = 1'b1;
		prep_en = 1'b0;
		update = 1'b0;
		out_load = 1'b0;
		case (state_q)
			bgmr_pkg::ST_IDLE: in_stall = 1'b0;
			bgmr_pkg::ST_PREP: prep_en = 1'b1;
			bgmr_pkg::ST_UPDATE: update = 1'b1;
			bgmr_pkg::ST_EMIT: out_load = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bgmr_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Capture the frame
	always_ff @(posedge clk) begin
		if (accept) begin
			in_s1 <= in_item;
		end
	end

	bgmr_prep u_prep (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (prep_en),
		.keep        (in_s1.shape_mode[0]),
		.color_mode  (in_s1.color_mode),
		.now_ms      (in_s1.now_ms),
		.fall_delay  (fall_delay_q),
		.color_one   (color_one_q),
		.color_two   (color_two_q),
		.color_three (color_three_q),
		.paint_s2    (paint_s2)
	);

	// Drive the column cells
	assign cell_ctl.update = update;
	assign cell_ctl.shift = out_load;
	assign cell_ctl.keep = in_s1.shape_mode[0];
	assign cell_ctl.line = in_s1.shape_mode[1];
	assign cell_ctl.band = in_s1.color_mode[3];
	assign cell_ctl.paint = paint_s2;

	assign level[0] = in_s1.level_col0;
	assign level[1] = in_s1.level_col1;
	assign level[2] = in_s1.level_col2;
	assign level[3] = in_s1.level_col3;
	assign level[4] = in_s1.level_col4;
	assign level[5] = in_s1.level_col5;
	assign level[6] = in_s1.level_col6;

	for (genvar c = 0; c < bgmr_pkg::COLUMNS; c++) begin : g_col
		bgmr_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (cell_ctl),
			.level    (level[c]),
			.shift_in (col_head[(c + 1) % bgmr_pkg::COLUMNS]),
			.head     (col_head[c])
		);
	end

	// Count emitted pixels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_cnt_q <= '0;
		end else if (update) begin
			pix_cnt_q <= '0;
		end else if (out_load) begin
			pix_cnt_q <= pix_cnt_q + 1'b1;
		end
	end

	// Output register: load the ring head, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_item_q.pixel_index <= pix_cnt_q;
			out_item_q.pixel_color <= col_head[0];
			out_item_q.last_pixel <= (pix_cnt_q == bgmr_pkg::LAST_PIX);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

`ifndef SYNTHESIS
	a_frame_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == bgmr_pkg::ST_PREP)
		else $error("accepted item did not start the prep step");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bgmr_pkg::ST_EMIT |-> pix_cnt_q <= bgmr_pkg::LAST_PIX)
		else $error("pixel counter ran past the frame");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.last_pixel |-> out_item.pixel_index == bgmr_pkg::LAST_PIX)
		else $error("last pixel flag on the wrong index");

	a_no_update_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		update |-> !out_load && $past(prep_en))
		else $error("cell update out of sequence");
`endif

endmodule
